// ===== src/lca_pkg.sv =====
// Shared types and constants for the binary-lifting LCA block.
// No dependencies; imported by the top level and the checker.
`default_nettype none
package lca_pkg;
   localparam int NODE_W    = 10;
   localparam int CNT_W     = 11;
   localparam int MAX_NODES = 1024;
   localparam logic [CNT_W-1:0] NIL       = 11'd1024;
   localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_BUILD = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_NOTREADY = 2'd2;
   localparam logic [1:0] ST_HASPAR  = 2'd3;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] ancestor_node;
      logic [1:0]        status;
   } rsp_type;
endpackage
`default_nettype wire

// ===== src/lca_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module lca_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/tree_lca_binary_lifting.sv =====
// Top level of the binary-lifting LCA block: command sequencer and datapath.
// Depends on lca_pkg and lca_ram.
//
//  channel   ports                         direction  handshake
//  request   start, busy, req_item         in         taken when start & !busy
//  response  rsp_valid, rsp_item           out        one-cycle strobe, no stall
//  csr       csr_we, csr_wdata (node_count) in         written when csr_we
//
// From the taking edge to the strobe: clear makes one sweep over the child lists,
// and a query reads one ancestor row per step on the single table read port.
// Build clears depths and the table, scans the nodes for the root, visits each
// reached node, and for each newly reached child builds its row from dependent
// ancestor-row reads.
// Reset starts a clearing pass, busy high; csr writes are taken.
// The response is strobed once and busy falls in the same cycle.
`default_nettype none
module tree_lca_binary_lifting #(
   parameter int LIFT_LEVELS = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire lca_pkg::req_type       req_item,
   output logic                        rsp_valid,
   output lca_pkg::rsp_type            rsp_item,
   input  wire logic                   csr_we,
   input  wire logic [10:0]            csr_wdata
);
   import lca_pkg::*;

   localparam int KW = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
   localparam int RW = LIFT_LEVELS * CNT_W;
   localparam logic [KW-1:0] K_TOP = KW'(LIFT_LEVELS - 1);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_CLR_ALL  = 5'd1;
   localparam logic [4:0] S_DISP     = 5'd2;
   localparam logic [4:0] S_CLR_TREE = 5'd3;
   localparam logic [4:0] S_ADD_RD   = 5'd4;
   localparam logic [4:0] S_ADD_CHK  = 5'd5;
   localparam logic [4:0] S_CLR_TAB  = 5'd6;
   localparam logic [4:0] S_FIND_RD  = 5'd7;
   localparam logic [4:0] S_FIND_CHK = 5'd8;
   localparam logic [4:0] S_W_POP    = 5'd9;
   localparam logic [4:0] S_W_U      = 5'd10;
   localparam logic [4:0] S_W_U2     = 5'd11;
   localparam logic [4:0] S_W_C      = 5'd12;
   localparam logic [4:0] S_W_C2     = 5'd13;
   localparam logic [4:0] S_W_L1     = 5'd14;
   localparam logic [4:0] S_W_L2     = 5'd15;
   localparam logic [4:0] S_W_WR     = 5'd16;
   localparam logic [4:0] S_Q_RA     = 5'd17;
   localparam logic [4:0] S_Q_RB     = 5'd18;
   localparam logic [4:0] S_Q_D      = 5'd19;
   localparam logic [4:0] S_L1       = 5'd20;
   localparam logic [4:0] S_L1B      = 5'd21;
   localparam logic [4:0] S_Q_EQ     = 5'd22;
   localparam logic [4:0] S_Q_U      = 5'd23;
   localparam logic [4:0] S_Q_V      = 5'd24;
   localparam logic [4:0] S_Q_C      = 5'd25;
   localparam logic [4:0] S_Q_FR     = 5'd26;
   localparam logic [4:0] S_Q_F      = 5'd27;

   typedef logic [LIFT_LEVELS-1:0][CNT_W-1:0] row_type;

   // sequencer and datapath registers
   logic [4:0]        state_ff, state_in;
   logic [NODE_W-1:0] i_ff, i_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [NODE_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [CNT_W-1:0]  ncount_ff, ncount_in;
   logic              built_ff, built_in;
   logic [CNT_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [NODE_W-1:0] u_ff, u_in, v_ff, v_in, root_ff, root_in;
   logic [CNT_W-1:0]  du_ff, du_in, c_ff, c_in, nsib_ff, nsib_in;
   logic [CNT_W-1:0]  gap_ff, gap_in, pu_ff, pu_in;
   row_type           row_ff, row_in;
   logic [KW-1:0]     k_ff, k_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // memory ports
   logic              hp_we, hp_wd, hp_q;
   logic [NODE_W-1:0] hp_wa, hp_ra;
   logic              fc_we, ns_we, dep_we, anc_we, wq_we;
   logic [NODE_W-1:0] fc_wa, fc_ra, ns_wa, ns_ra, dep_wa, dep_ra, anc_wa, anc_ra;
   logic [NODE_W-1:0] wq_wa, wq_ra, wq_wd, wq_q;
   logic [CNT_W-1:0]  fc_wd, fc_q, ns_wd, ns_q, dep_wd, dep_q;
   row_type           anc_wd, anc_q;

   logic [CNT_W-1:0]  live;
   logic              a_bad, b_bad;
   logic [16:0]       step;
   logic [CNT_W-1:0]  p_cur;

   lca_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_has_parent (
      .clock(clock), .wr_en(hp_we), .wr_addr(hp_wa), .wr_data(hp_wd),
      .rd_addr(hp_ra), .rd_data(hp_q));
   lca_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_first_child (
      .clock(clock), .wr_en(fc_we), .wr_addr(fc_wa), .wr_data(fc_wd),
      .rd_addr(fc_ra), .rd_data(fc_q));
   lca_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_next_sibling (
      .clock(clock), .wr_en(ns_we), .wr_addr(ns_wa), .wr_data(ns_wd),
      .rd_addr(ns_ra), .rd_data(ns_q));
   lca_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_node_depth (
      .clock(clock), .wr_en(dep_we), .wr_addr(dep_wa), .wr_data(dep_wd),
      .rd_addr(dep_ra), .rd_data(dep_q));
   lca_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_ancestor (
      .clock(clock), .wr_en(anc_we), .wr_addr(anc_wa), .wr_data(anc_wd),
      .rd_addr(anc_ra), .rd_data(anc_q));
   lca_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_walk_queue (
      .clock(clock), .wr_en(wq_we), .wr_addr(wq_wa), .wr_data(wq_wd),
      .rd_addr(wq_ra), .rd_data(wq_q));

   // node count as used: zero acts as one, anything above the array acts as full
   always_comb begin
      if (ncount_ff == '0) begin
         live = CNT_W'(1);
      end else if (ncount_ff > NIL) begin
         live = NIL;
      end else begin
         live = ncount_ff;
      end
   end

   assign a_bad = ({1'b0, a_ff} >= live);
   assign b_bad = ({1'b0, b_ff} >= live);
   assign step  = 17'd1 << k_ff;
   assign p_cur = row_ff[k_ff - KW'(1)];

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      cmd_in       = cmd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      ncount_in    = ncount_ff;
      built_in     = built_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      root_in      = root_ff;
      du_in        = du_ff;
      c_in         = c_ff;
      nsib_in      = nsib_ff;
      gap_in       = gap_ff;
      pu_in        = pu_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      hp_we  = 1'b0;  hp_wa  = i_ff;  hp_wd  = 1'b0;  hp_ra  = b_ff;
      fc_we  = 1'b0;  fc_wa  = i_ff;  fc_wd  = NIL;   fc_ra  = a_ff;
      ns_we  = 1'b0;  ns_wa  = b_ff;  ns_wd  = fc_q;  ns_ra  = c_ff[NODE_W-1:0];
      dep_we = 1'b0;  dep_wa = i_ff;  dep_wd = NIL;   dep_ra = a_ff;
      anc_we = 1'b0;  anc_wa = i_ff;  anc_wd = {LIFT_LEVELS{NIL}};  anc_ra = u_ff;
      wq_we  = 1'b0;  wq_wa  = tail_ff[NODE_W-1:0];  wq_wd = c_ff[NODE_W-1:0];
      wq_ra  = head_ff[NODE_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_item.cmd;
               a_in     = req_item.node_a;
               b_in     = req_item.node_b;
               state_in = S_DISP;
            end
         end
         S_CLR_ALL, S_CLR_TREE, S_CLR_TAB: begin
            // sweep one entry a cycle
            if (state_ff != S_CLR_TAB) begin
               hp_we = 1'b1;
               fc_we = 1'b1;
            end
            if (state_ff != S_CLR_TREE) begin
               dep_we = 1'b1;
               anc_we = 1'b1;
            end
            i_in = i_ff + NODE_W'(1);
            if (i_ff == NODE_W'(MAX_NODES - 1)) begin
               i_in = '0;
               if (state_ff == S_CLR_ALL) begin
                  state_in = S_IDLE;
               end else if (state_ff == S_CLR_TREE) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{ancestor_node: '0, status: ST_OK};
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_FIND_RD;
               end
            end
         end
         S_DISP: begin
            i_in = '0;
            case (cmd_ff)
               CMD_CLEAR: begin
                  built_in = 1'b0;
                  state_in = S_CLR_TREE;
               end
               CMD_ADD: begin
                  if (a_bad || b_bad) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{ancestor_node: '0, status: ST_RANGE};
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_ADD_RD;
                  end
               end
               CMD_BUILD: begin
                  built_in = 1'b0;
                  state_in = S_CLR_TAB;
               end
               CMD_QUERY: begin
                  if (a_bad || b_bad) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{ancestor_node: '0, status: ST_RANGE};
                     state_in     = S_IDLE;
                  end else if (!built_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{ancestor_node: '0, status: ST_NOTREADY};
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_Q_RA;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_ADD_RD: begin
            state_in = S_ADD_CHK;
         end
         S_ADD_CHK: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (hp_q) begin
               rsp_in = '{ancestor_node: '0, status: ST_HASPAR};
            end else begin
               // push the child on the front of the parent's list
               ns_we    = 1'b1;
               fc_we    = 1'b1;
               fc_wa    = a_ff;
               fc_wd    = {1'b0, b_ff};
               hp_we    = 1'b1;
               hp_wa    = b_ff;
               hp_wd    = 1'b1;
               built_in = 1'b0;
               rsp_in   = '{ancestor_node: '0, status: ST_OK};
            end
         end
         S_FIND_RD: begin
            hp_ra    = i_ff;
            state_in = S_FIND_CHK;
         end
         S_FIND_CHK: begin
            if (!hp_q) begin
               root_in  = i_ff;
               dep_we   = 1'b1;
               dep_wd   = '0;
               wq_we    = 1'b1;
               wq_wa    = '0;
               wq_wd    = i_ff;
               head_in  = '0;
               tail_in  = CNT_W'(1);
               state_in = S_W_POP;
            end else if (({1'b0, i_ff} + CNT_W'(1)) >= live) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{ancestor_node: '0, status: ST_NOTREADY};
               state_in     = S_IDLE;
            end else begin
               i_in     = i_ff + NODE_W'(1);
               state_in = S_FIND_RD;
            end
         end
         S_W_POP: begin
            if (head_ff == tail_ff) begin
               built_in     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '{ancestor_node: root_ff, status: ST_OK};
               state_in     = S_IDLE;
            end else begin
               head_in  = head_ff + CNT_W'(1);
               state_in = S_W_U;
            end
         end
         S_W_U: begin
            u_in     = wq_q;
            fc_ra    = wq_q;
            dep_ra   = wq_q;
            state_in = S_W_U2;
         end
         S_W_U2: begin
            du_in    = dep_q;
            c_in     = fc_q;
            state_in = S_W_C;
         end
         S_W_C: begin
            dep_ra = c_ff[NODE_W-1:0];
            if (c_ff >= live) begin
               state_in = S_W_POP;
            end else begin
               state_in = S_W_C2;
            end
         end
         S_W_C2: begin
            nsib_in = ns_q;
            if (dep_q == NIL && tail_ff < NIL) begin
               dep_we    = 1'b1;
               dep_wa    = c_ff[NODE_W-1:0];
               dep_wd    = du_ff + CNT_W'(1);
               row_in    = {LIFT_LEVELS{NIL}};
               row_in[0] = {1'b0, u_ff};
               k_in      = KW'(1);
               state_in  = (LIFT_LEVELS == 1) ? S_W_WR : S_W_L1;
            end else begin
               c_in     = ns_q;
               state_in = S_W_C;
            end
         end
         S_W_L1: begin
            // fetch the row of the 2^(k-1) ancestor; a missing one ends the row
            anc_ra = p_cur[NODE_W-1:0];
            if (p_cur >= NIL) begin
               state_in = S_W_WR;
            end else begin
               state_in = S_W_L2;
            end
         end
         S_W_L2: begin
            row_in[k_ff] = anc_q[k_ff - KW'(1)];
            if (k_ff == K_TOP) begin
               state_in = S_W_WR;
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = S_W_L1;
            end
         end
         S_W_WR: begin
            anc_we   = 1'b1;
            anc_wa   = c_ff[NODE_W-1:0];
            anc_wd   = row_ff;
            wq_we    = 1'b1;
            tail_in  = tail_ff + CNT_W'(1);
            c_in     = nsib_ff;
            state_in = S_W_C;
         end
         S_Q_RA: begin
            dep_ra   = a_ff;
            state_in = S_Q_RB;
         end
         S_Q_RB: begin
            du_in    = dep_q;
            dep_ra   = b_ff;
            state_in = S_Q_D;
         end
         S_Q_D: begin
            if (du_ff == NIL || dep_q == NIL) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{ancestor_node: '0, status: ST_NOTREADY};
               state_in     = S_IDLE;
            end else begin
               if (du_ff > dep_q) begin
                  u_in   = b_ff;
                  v_in   = a_ff;
                  gap_in = du_ff - dep_q;
               end else begin
                  u_in   = a_ff;
                  v_in   = b_ff;
                  gap_in = dep_q - du_ff;
               end
               k_in     = K_TOP;
               state_in = S_L1;
            end
         end
         S_L1: begin
            anc_ra = v_ff;
            if ({6'b0, gap_ff} >= step) begin
               state_in = S_L1B;
            end else if (k_ff == '0) begin
               state_in = S_Q_EQ;
            end else begin
               k_in = k_ff - KW'(1);
            end
         end
         S_L1B: begin
            if (anc_q[k_ff] < NIL) begin
               v_in   = anc_q[k_ff][NODE_W-1:0];
               gap_in = gap_ff - step[CNT_W-1:0];
            end
            if (k_ff == '0) begin
               state_in = S_Q_EQ;
            end else begin
               k_in     = k_ff - KW'(1);
               state_in = S_L1;
            end
         end
         S_Q_EQ: begin
            if (u_ff == v_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{ancestor_node: u_ff, status: ST_OK};
               state_in     = S_IDLE;
            end else begin
               k_in     = K_TOP;
               state_in = S_Q_U;
            end
         end
         S_Q_U: begin
            anc_ra   = u_ff;
            state_in = S_Q_V;
         end
         S_Q_V: begin
            pu_in    = anc_q[k_ff];
            anc_ra   = v_ff;
            state_in = S_Q_C;
         end
         S_Q_C: begin
            if (pu_ff != anc_q[k_ff] && pu_ff < NIL && anc_q[k_ff] < NIL) begin
               u_in = pu_ff[NODE_W-1:0];
               v_in = anc_q[k_ff][NODE_W-1:0];
            end
            if (k_ff == '0) begin
               state_in = S_Q_FR;
            end else begin
               k_in     = k_ff - KW'(1);
               state_in = S_Q_U;
            end
         end
         S_Q_FR: begin
            anc_ra   = u_ff;
            state_in = S_Q_F;
         end
         S_Q_F: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (anc_q[0] >= NIL) begin
               rsp_in = '{ancestor_node: '0, status: ST_NOTREADY};
            end else begin
               rsp_in = '{ancestor_node: anc_q[0][NODE_W-1:0], status: ST_OK};
            end
         end
         default: state_in = S_IDLE;
      endcase

      // csr writes land in any state; drop the built flag
      if (csr_we) begin
         ncount_in = csr_wdata;
         built_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR_ALL;
         i_ff         <= '0;
         ncount_ff    <= CNT_RESET;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         ncount_ff    <= ncount_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff  <= cmd_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      root_ff <= root_in;
      du_ff   <= du_in;
      c_ff    <= c_in;
      nsib_ff <= nsib_in;
      gap_ff  <= gap_in;
      pu_ff   <= pu_in;
      row_ff  <= row_in;
      k_ff    <= k_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule
`default_nettype wire

// ===== src/lca_checker.sv =====
// Port-level checks for the LCA block, bound to the top level.
// Depends on lca_pkg and tree_lca_binary_lifting.
`default_nettype none
module lca_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire lca_pkg::rsp_type rsp_item
);
   import lca_pkg::*;

   // a taken request drives busy high
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("request taken but busy low");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe longer than a cycle");

   a_idle_at_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy high at response");

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_OK |-> rsp_item.ancestor_node == '0)
      else $error("nonzero node on failed response");
endmodule

bind tree_lca_binary_lifting lca_checker u_lca_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_item(rsp_item));
`default_nettype wire
